### sv/rdmg_pkg.sv
package rdmg_pkg;

  localparam int unsigned DefMaxRows = 63;
  localparam int unsigned DefMaxCols = 63;
  localparam logic [15:0] SeedReset  = 16'd44257;
  localparam logic [15:0] LfsrTaps   = 16'hB400;

  // register indexes
  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegSeed = 2'd2;

  // operations and status codes
  localparam logic OpGen  = 1'b0;
  localparam logic OpRead = 1'b1;
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadSize = 2'd1;
  localparam logic [1:0] StBadCell = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_START,
    S_TOP,
    S_TOPW,
    S_NEIGH,
    S_VISW,
    S_CARVE,
    S_RDW,
    S_PUSH
  } state_e;

  // direction orders, direction k in bits 2k+1..2k
  function automatic logic [7:0] perm_order(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'hE4; 5'd1:  v = 8'hB4; 5'd2:  v = 8'hD8; 5'd3:  v = 8'h78;
      5'd4:  v = 8'h9C; 5'd5:  v = 8'h6C; 5'd6:  v = 8'hE1; 5'd7:  v = 8'hB1;
      5'd8:  v = 8'hC9; 5'd9:  v = 8'h39; 5'd10: v = 8'h8D; 5'd11: v = 8'h2D;
      5'd12: v = 8'hD2; 5'd13: v = 8'h72; 5'd14: v = 8'hC6; 5'd15: v = 8'h36;
      5'd16: v = 8'h4E; 5'd17: v = 8'h1E; 5'd18: v = 8'h93; 5'd19: v = 8'h63;
      5'd20: v = 8'h87; 5'd21: v = 8'h27; 5'd22: v = 8'h4B; 5'd23: v = 8'h1B;
      default: v = 8'hE4;
    endcase
    return v;
  endfunction

  // one Galois step
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    return v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
  endfunction

  // value mod 24: residue mod 3 from the base-4 digit sum (4 mod 3 = 1),
  // residue mod 8 from the low bits, then x = v mod 8 + 8k with k in 0..2
  function automatic logic [4:0] mod24(input logic [15:0] v);
    logic [9:0] s;
    logic [1:0] a;
    logic [1:0] b3;
    logic [1:0] k;
    s = 10'(v[1:0]) + 10'(v[3:2]) + 10'(v[5:4]) + 10'(v[7:6]) + 10'(v[9:8])
      + 10'(v[11:10]) + 10'(v[13:12]) + 10'(v[15:14]);
    s = 10'(s[1:0]) + 10'(s[3:2]) + 10'(s[5:4]);
    s = 10'(s[1:0]) + 10'(s[3:2]);
    a = (s[2:0] >= 3'd3) ? 2'(s[2:0] - 3'd3) : s[1:0];
    // low three bits mod 3
    unique case (v[2:0])
      3'd0, 3'd3, 3'd6: b3 = 2'd0;
      3'd1, 3'd4, 3'd7: b3 = 2'd1;
      default:          b3 = 2'd2;
    endcase
    // 8 mod 3 = 2, so k = 2 * (a - b3) mod 3
    if (a == b3) k = 2'd0;
    else if (a == ((b3 == 2'd2) ? 2'd0 : b3 + 2'd1)) k = 2'd2;
    else k = 2'd1;
    return {k, v[2:0]};
  endfunction

endpackage

### sv/rdmg_ram.sv
module rdmg_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/random_dfs_maze_generator.sv
// Recursive backtracker maze generator.
// Input beats on s_axis: tdata = operation, row, col from bit 0 up.
// Output beats on m_axis: tdata = status, cell_open, visited_count from bit 0 up.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i, index 0 rows, 1 cols,
// 2 seed; the user writes them only while idle; the block does not enforce it.
// An error result is registered from the decode state S_START; a read result
// passes S_START and then S_RDW, which registers it. A generate first clears
// the open map and visited map (one entry per cycle, over MAX_ROWS*MAX_COLS
// open-map entries, here 3969), writes the start cell, then walks the search:
// each stack step passes S_TOP and S_TOPW, a neighbor inside the grid adds
// S_NEIGH and S_VISW, and a carved neighbor adds S_CARVE.
// The rate is set by the one write and one read per cycle on each memory.
// One item is worked on at a time; s_axis_tready is low while busy.
// Reset needs no clearing pass: the open map reads as walls because a
// "generated" flag masks reads until the first generate completes its clear.
// When the receiver stalls the result waits in the output register and the
// block accepts no further beat until it is taken.
module random_dfs_maze_generator
  import rdmg_pkg::*;
#(
  parameter int unsigned MaxRows = DefMaxRows,
  parameter int unsigned MaxCols = DefMaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // operation, row, col
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, cell_open, visited_count
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned VRows  = (MaxRows + 1) / 2;
  localparam int unsigned VCols  = (MaxCols + 1) / 2;
  localparam int unsigned OpenD  = MaxRows * MaxCols;
  localparam int unsigned VisD   = VRows * VCols;
  localparam int unsigned OAw    = $clog2(OpenD);
  localparam int unsigned VAw    = $clog2(VisD);
  localparam int unsigned SdW    = $clog2(VisD + 1);
  localparam int unsigned FrW    = 6 + 6 + 5 + 2;

  state_e state_q, state_d;
  logic [5:0]  rows_q, cols_q;
  logic [15:0] seed_q, lfsr_q, lfsr_d;
  logic        op_q;
  logic [5:0]  r_q, c_q;
  logic [SdW-1:0] sp_q, sp_d;
  logic [10:0] cnt_q, cnt_d;
  logic [OAw-1:0] clr_q, clr_d;
  logic        gen_done_q, gen_done_d;
  logic [5:0]  fr_q, fc_q, nr_q, nc_q;
  logic [5:0]  fr_d, fc_d, nr_d, nc_d;
  logic        ovld_q, ovld_d;
  logic [1:0]  st_q, st_d;
  logic        op_open_q, op_open_d;
  logic [10:0] ocnt_q, ocnt_d;

  // memory ports
  logic           o_we, v_we, s_we;
  logic [OAw-1:0] o_wa, o_ra;
  logic           o_wd, o_rd;
  logic [VAw-1:0] v_wa, v_ra;
  logic           v_wd, v_rd;
  logic [VAw-1:0] s_wa, s_ra;
  logic [FrW-1:0] s_wd, s_rd;

  rdmg_ram #(.Width(1), .Depth(OpenD)) u_open (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd), .raddr_i(o_ra),
    .rdata_o(o_rd));
  rdmg_ram #(.Width(1), .Depth(VisD)) u_vis (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra),
    .rdata_o(v_rd));
  rdmg_ram #(.Width(FrW), .Depth(VisD)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra),
    .rdata_o(s_rd));

  function automatic logic [OAw-1:0] oaddr(input logic [5:0] r, input logic [5:0] c);
    return OAw'(32'(r) * MaxCols + 32'(c));
  endfunction
  function automatic logic [VAw-1:0] vaddr(input logic [5:0] r, input logic [5:0] c);
    return VAw'(32'(r[5:1]) * VCols + 32'(c[5:1]));
  endfunction

  // size and cell checks on the latched beat
  logic size_bad, cell_out, start_even;
  assign size_bad = (rows_q < 6'd3) || (cols_q < 6'd3) || !rows_q[0] || !cols_q[0]
                  || (32'(rows_q) > MaxRows) || (32'(cols_q) > MaxCols);
  assign cell_out = (r_q >= rows_q) || (c_q >= cols_q);
  assign start_even = !r_q[0] || !c_q[0];

  logic clr_last;
  assign clr_last = (32'(clr_q) == OpenD - 1);

  // frame fields on the top of stack
  logic [5:0] tr, tc, tnr, tnc;
  logic [4:0] tord;
  logic [1:0] tpos, dir;
  logic       nb_ok;
  logic [7:0] perm;
  assign {tpos, tord, tc, tr} = s_rd;
  assign perm = perm_order(tord);
  assign dir  = 2'(perm >> {tpos, 1'b0});

  // neighbor two steps away in the current direction
  always_comb begin
    tnr = tr;
    tnc = tc;
    unique case (dir)
      2'd0: begin nb_ok = tr > 6'd2; tnr = tr - 6'd2; end
      2'd1: begin nb_ok = tc > 6'd2; tnc = tc - 6'd2; end
      2'd2: begin nb_ok = (7'(tr) + 7'd2) < 7'(rows_q); tnr = tr + 6'd2; end
      default: begin nb_ok = (7'(tc) + 7'd2) < 7'(cols_q); tnc = tc + 6'd2; end
    endcase
  end

  logic [15:0] lfsr_nx;
  assign lfsr_nx = lfsr_step(lfsr_q);

  assign s_axis_tready = (state_q == S_IDLE) && !ovld_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 6'(DefMaxRows);
      cols_q <= 6'(DefMaxCols);
      seed_q <= SeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRows: rows_q <= cfg_data_i[5:0];
        RegCols: cols_q <= cfg_data_i[5:0];
        RegSeed: seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) state_d = S_START;
      end
      S_START: begin
        priority if (size_bad || cell_out || ((op_q == OpGen) && start_even)) begin
          state_d = S_IDLE;
        end else if (op_q == OpRead) begin
          state_d = S_RDW;
        end else begin
          state_d = S_CLEAR;
        end
      end
      S_RDW:   state_d = S_IDLE;
      S_CLEAR: begin
        if (clr_last) state_d = S_PUSH;
      end
      S_PUSH:  state_d = S_TOP;
      S_TOP:   state_d = S_TOPW;
      S_TOPW: begin
        priority if (sp_q == '0) state_d = S_IDLE;
        else if (nb_ok) state_d = S_NEIGH;
        else state_d = S_TOP;
      end
      S_NEIGH: state_d = S_VISW;
      S_VISW:  state_d = v_rd ? S_TOP : S_CARVE;
      S_CARVE: state_d = S_TOP;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    lfsr_d = lfsr_q; sp_d = sp_q; cnt_d = cnt_q;
    clr_d = clr_q; gen_done_d = gen_done_q;
    fr_d = fr_q; fc_d = fc_q; nr_d = nr_q; nc_d = nc_q;
    ovld_d = ovld_q; st_d = st_q; op_open_d = op_open_q; ocnt_d = ocnt_q;
    o_we = 1'b0; o_wa = clr_q; o_wd = 1'b0; o_ra = oaddr(r_q, c_q);
    v_we = 1'b0; v_wa = VAw'(clr_q); v_wd = 1'b0; v_ra = vaddr(nr_q, nc_q);
    s_we = 1'b0; s_wa = VAw'(sp_q); s_wd = '0; s_ra = VAw'(sp_q - SdW'(1));
    if (m_axis_tvalid && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      S_START: begin
        // decode the latched beat
        op_open_d = 1'b0; ocnt_d = '0; clr_d = '0;
        priority if (size_bad) begin
          st_d = StBadSize; ovld_d = 1'b1;
        end else if (cell_out || ((op_q == OpGen) && start_even)) begin
          st_d = StBadCell; ovld_d = 1'b1;
        end else begin
          st_d = StOk;
        end
      end
      S_RDW: begin
        op_open_d = gen_done_q & o_rd; ovld_d = 1'b1;
      end
      S_CLEAR: begin
        o_we = 1'b1;
        v_we = (32'(clr_q) < VisD);
        if (clr_last) begin
          lfsr_d = lfsr_step((seed_q == '0) ? 16'd1 : seed_q);
          sp_d = SdW'(1); cnt_d = 11'd1; gen_done_d = 1'b1;
        end else begin
          clr_d = clr_q + OAw'(1);
        end
      end
      S_PUSH: begin
        // mark and open the start cell, push its frame
        o_we = 1'b1; o_wa = oaddr(r_q, c_q); o_wd = 1'b1;
        v_we = 1'b1; v_wa = vaddr(r_q, c_q); v_wd = 1'b1;
        s_we = 1'b1; s_wa = '0; s_wd = {2'd0, mod24(lfsr_q), c_q, r_q};
      end
      S_TOPW: begin
        // stack top now valid on s_rd
        if (sp_q == '0) begin
          ocnt_d = cnt_q; ovld_d = 1'b1;
        end else begin
          fr_d = tr; fc_d = tc;
          nr_d = tnr; nc_d = tnc;
          // pop or advance position
          if (tpos == 2'd3) begin
            sp_d = sp_q - SdW'(1);
          end else begin
            s_we = 1'b1; s_wa = VAw'(sp_q - SdW'(1));
            s_wd = {tpos + 2'd1, tord, tc, tr};
          end
        end
      end
      S_VISW: begin
        if (!v_rd) begin
          v_we = 1'b1; v_wa = vaddr(nr_q, nc_q); v_wd = 1'b1;
          o_we = 1'b1; o_wd = 1'b1;
          o_wa = oaddr(6'((7'(fr_q) + 7'(nr_q)) >> 1), 6'((7'(fc_q) + 7'(nc_q)) >> 1));
        end
      end
      S_CARVE: begin
        o_we = 1'b1; o_wd = 1'b1; o_wa = oaddr(nr_q, nc_q);
        cnt_d = cnt_q + 11'd1;
        if (32'(sp_q) < VisD) begin
          lfsr_d = lfsr_nx;
          s_we = 1'b1; s_wa = VAw'(sp_q);
          s_wd = {2'd0, mod24(lfsr_nx), nc_q, nr_q};
          sp_d = sp_q + SdW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; lfsr_q <= SeedReset; sp_q <= '0; cnt_q <= '0;
      clr_q <= '0; gen_done_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; lfsr_q <= lfsr_d; sp_q <= sp_d; cnt_q <= cnt_d;
      clr_q <= clr_d; gen_done_q <= gen_done_d; ovld_q <= ovld_d;
    end
  end

  // beat and result registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[0]; r_q <= s_axis_tdata[6:1]; c_q <= s_axis_tdata[12:7];
    end
    fr_q <= fr_d; fc_q <= fc_d; nr_q <= nr_d; nc_q <= nc_d;
    st_q <= st_d; op_open_q <= op_open_d; ocnt_q <= ocnt_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, ocnt_q, op_open_q, st_q};

  // a stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  // no new beat while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready);
  // legal status and zero padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] <= StBadCell) && (m_axis_tdata[15:14] == 2'b00));
  // stack never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= VisD);
endmodule

### tb/sv/random_dfs_maze_checker.sv
`timescale 1ns / 100ps

// Watches the request and result streams and the config port, predicts each
// result with its own maze carver, and compares field by field.
module random_dfs_maze_checker
  import rdmg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int VCols = (DefMaxCols + 1) / 2;
  localparam int VCells = ((DefMaxRows + 1) / 2) * VCols;

  typedef struct packed {
    logic [10:0] visited_count;
    logic        cell_open;
    logic [1:0]  status;
  } maze_result_t;

  typedef struct {
    int r;
    int c;
    int order;
    int pos;
  } walk_frame_t;

  logic [5:0]  grid_rows = 6'd63;
  logic [5:0]  grid_cols = 6'd63;
  logic [15:0] seed_reg  = SeedReset;
  logic [15:0] lfsr_q;
  bit          open_map [DefMaxRows * DefMaxCols];
  bit          seen_map [VCells];
  maze_result_t expected_results [$];
  int          fails = 0;

  assign pending_o = expected_results.size();
  assign fail_count_o = fails;

  function automatic logic [7:0] order_bits(int idx);
    logic [7:0] tbl [24] = '{8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C, 8'hE1, 8'hB1,
                             8'hC9, 8'h39, 8'h8D, 8'h2D, 8'hD2, 8'h72, 8'hC6, 8'h36,
                             8'h4E, 8'h1E, 8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B};
    return tbl[idx];
  endfunction

  function automatic int next_order();
    lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ 16'hB400) : (lfsr_q >> 1);
    return int'(lfsr_q) % 24;
  endfunction

  // depth-first carve; returns odd cells reached
  function automatic int carve_maze(int r0, int c0);
    walk_frame_t stk [$];
    walk_frame_t f;
    int count, dir, nr, nc, vi;
    bit ok;
    count = 1;
    foreach (open_map[i]) open_map[i] = 0;
    foreach (seen_map[i]) seen_map[i] = 0;
    lfsr_q = (seed_reg == 0) ? 16'd1 : seed_reg;
    seen_map[(r0 >> 1) * VCols + (c0 >> 1)] = 1;
    open_map[r0 * DefMaxCols + c0] = 1;
    stk.push_back('{r0, c0, next_order(), 0});
    while (stk.size() > 0) begin
      f = stk[$];
      dir = (order_bits(f.order) >> (2 * f.pos)) & 3;
      if (f.pos >= 3) void'(stk.pop_back());
      else stk[$].pos = f.pos + 1;
      nr = f.r;
      nc = f.c;
      case (dir)
        0: begin ok = f.r > 2; nr = f.r - 2; end
        1: begin ok = f.c > 2; nc = f.c - 2; end
        2: begin ok = f.r + 2 < grid_rows; nr = f.r + 2; end
        default: begin ok = f.c + 2 < grid_cols; nc = f.c + 2; end
      endcase
      if (!ok) continue;
      vi = (nr >> 1) * VCols + (nc >> 1);
      if (seen_map[vi]) continue;
      seen_map[vi] = 1;
      open_map[((f.r + nr) >> 1) * DefMaxCols + ((f.c + nc) >> 1)] = 1;
      open_map[nr * DefMaxCols + nc] = 1;
      count++;
      if (stk.size() < VCells) stk.push_back('{nr, nc, next_order(), 0});
    end
    return count;
  endfunction

  function automatic maze_result_t predict_result(logic op, int r, int c);
    maze_result_t res;
    res = '0;
    res.status = StOk;
    if (grid_rows < 3 || grid_cols < 3 || !grid_rows[0] || !grid_cols[0]
        || grid_rows > DefMaxRows || grid_cols > DefMaxCols)
      res.status = StBadSize;
    else if (r >= grid_rows || c >= grid_cols)
      res.status = StBadCell;
    else if (op == OpGen) begin
      if (r % 2 == 0 || c % 2 == 0) res.status = StBadCell;
      else res.visited_count = 11'(carve_maze(r, c));
    end else
      res.cell_open = open_map[r * DefMaxCols + c];
    return res;
  endfunction

  // config writes, request beats and result beats
  always @(posedge clk_i) begin
    maze_result_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRows: grid_rows <= cfg_data_i[5:0];
          RegCols: grid_cols <= cfg_data_i[5:0];
          RegSeed: seed_reg <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_result(s_axis_tdata[0],
            int'(s_axis_tdata[6:1]), int'(s_axis_tdata[12:7])));
      if (m_axis_tvalid && m_axis_tready) begin
        got = maze_result_t'(m_axis_tdata[13:0]);
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_axis_tdata[15:14] !== 2'b0) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: status %0d/%0d open %0d/%0d count %0d/%0d (exp/got)",
                       want.status, got.status, want.cell_open, got.cell_open,
                       want.visited_count, got.visited_count);
          end
        end
      end
    end
  end

endmodule

### tb/sv/random_dfs_maze_generator_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the maze generator.
module random_dfs_maze_generator_test;
  import rdmg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // operation, row, col
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // status, cell_open, visited_count
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  bit          long_hold = 0;
  bit          hold_done = 0;

  random_dfs_maze_generator dut (.*);

  random_dfs_maze_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall pattern, one long hold-off on request
  initial begin
    int hold;
    @(posedge clk_i);
    forever begin
      if (long_hold && !hold_done) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        hold_done = 1;
      end
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) < 3);
      @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until all results are in, then idle before going on
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // offer one beat, with a random gap before it sometimes
  task automatic send_item(logic op, logic [5:0] r, logic [5:0] c);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, c, r, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // odd value within 1..lim-1
  function automatic logic [5:0] odd_below(int lim);
    return 6'(2 * $urandom_range(0, (lim - 2) / 2) + 1);
  endfunction

  initial begin
    int n, rr, cc;
    logic [5:0] sizes [6];
    sizes = '{6'd3, 6'd5, 6'd7, 6'd9, 6'd15, 6'd63};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default sizes, extremes of fields and error cases
    send_item(OpRead, 6'd0, 6'd0);   // read before any generate
    send_item(OpGen, 6'd1, 6'd1);
    send_item(OpRead, 6'd1, 6'd1);
    send_item(OpRead, 6'd62, 6'd62);
    send_item(OpRead, 6'd63, 6'd0);  // outside grid
    send_item(OpGen, 6'd2, 6'd1);    // even start
    send_item(OpGen, 6'd61, 6'd63);  // start outside
    send_item(OpGen, 6'd61, 6'd61);
    for (n = 0; n < 4; n++) send_item(OpRead, 6'($urandom), 6'($urandom));
    idle_input();
    drain();

    // minimal grid, zero seed
    write_reg(RegRows, 16'd3);
    write_reg(RegCols, 16'd3);
    write_reg(RegSeed, 16'd0);
    write_reg(2'd3, 16'hFFFF);       // unknown index
    send_item(OpGen, 6'd1, 6'd1);
    send_item(OpRead, 6'd1, 6'd2);
    send_item(OpRead, 6'd2, 6'd2);
    send_item(OpRead, 6'd3, 6'd1);
    idle_input();
    drain();

    // bad sizes: even, too small
    write_reg(RegRows, 16'd4);
    send_item(OpGen, 6'd1, 6'd1);
    send_item(OpRead, 6'd1, 6'd1);
    idle_input();
    drain();
    write_reg(RegRows, 16'd1);
    write_reg(RegCols, 16'hFFC0 | 16'd63);
    send_item(OpGen, 6'd1, 6'd1);
    idle_input();
    drain();

    // random phases; long receiver hold once, from phase 2 on
    for (int ph = 0; ph < 8; ph++) begin
      rr = int'(sizes[$urandom_range(0, 5)]);
      cc = int'(sizes[$urandom_range(0, 5)]);
      if (ph == 7) begin rr = 6; cc = 0; end
      write_reg(RegRows, 16'(rr));
      write_reg(RegCols, 16'(cc));
      write_reg(RegSeed, (ph == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
      if (ph == 2) long_hold = 1;
      for (n = 0; n < 12; n++) begin
        if (ph != 7 && ($urandom_range(0, 3) == 0))
          send_item(OpGen, odd_below(rr), odd_below(cc));
        else if ($urandom_range(0, 5) == 0)
          send_item(1'($urandom_range(0, 1)), 6'($urandom), 6'($urandom));
        else if (ph != 7)
          send_item(OpRead, 6'($urandom_range(0, rr - 1)), 6'($urandom_range(0, cc - 1)));
        else
          send_item(OpRead, 6'($urandom), 6'($urandom));
      end
      idle_input();
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
sv/rdmg_pkg.sv
sv/rdmg_ram.sv
sv/random_dfs_maze_generator.sv
tb/sv/random_dfs_maze_checker.sv
tb/sv/random_dfs_maze_generator_test.sv
